// ===== design/bpeq_pkg.sv =====
// Shared operation codes and sizing helpers for the button press event queue.
`default_nettype none

package bpeq_pkg;

   localparam int OP_W = 2;

   localparam logic [OP_W-1:0] OP_SCAN  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

// ===== design/bpeq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpeq_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [bpeq_pkg::addr_bits(DEPTH)-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [bpeq_pkg::addr_bits(DEPTH)-1:0]    rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/button_press_event_queue_core.sv =====
// Top level of the button press event queue: scan sequencer, key FIFO control, result register.
// Scan: one button compared per cycle from button 0; pop: ST_POP_WAIT waits for the key RAM
// read. Every item ends in ST_FINISH, which holds while rsp_stall blocks the result register.
// The next item is accepted the cycle after the result register loads.
// Synchronous active-high reset empties the FIFO, sets pressed level to 1 and all
// stored button levels to released; key RAM contents are not cleared.
`default_nettype none

module button_press_event_queue_core #(
   parameter int NUM_BUTTONS = 6,
   parameter int FIFO_DEPTH  = 32
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          csr_wr_en,
   input  wire logic                                          csr_wr_data,
   input  wire logic                                          req_valid,
   output      logic                                          req_stall,
   input  wire logic [bpeq_pkg::OP_W-1:0]                     req_operation,
   input  wire logic [NUM_BUTTONS-1:0]                        req_button_levels,
   input  wire logic [bpeq_pkg::addr_bits(NUM_BUTTONS)-1:0]   req_query_button,
   output      logic                                          rsp_valid,
   input  wire logic                                          rsp_stall,
   output      logic [$clog2(NUM_BUTTONS+1)-1:0]              rsp_key_code,
   output      logic                                          rsp_key_valid,
   output      logic                                          rsp_queried_level,
   output      logic                                          rsp_overflow_dropped
);

   localparam int QUERY_W = bpeq_pkg::addr_bits(NUM_BUTTONS);
   localparam int CODE_W  = $clog2(NUM_BUTTONS + 1);
   localparam int PTR_W   = bpeq_pkg::addr_bits(FIFO_DEPTH);
   localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

   localparam logic [CODE_W-1:0]  KEY_NONE = CODE_W'(NUM_BUTTONS);
   localparam logic [QUERY_W-1:0] LAST_IDX = QUERY_W'(NUM_BUTTONS - 1);
   localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(FIFO_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POP_WAIT,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic                     pressed_level_ff, pressed_level_in;
   logic [NUM_BUTTONS-1:0]   current_levels_ff, current_levels_in;
   logic [NUM_BUTTONS-1:0]   levels_ff, levels_in;
   logic [QUERY_W-1:0]       idx_ff, idx_in;
   logic [QUERY_W-1:0]       query_ff, query_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CODE_W-1:0]        code_ff, code_in;
   logic                     key_valid_ff, key_valid_in;
   logic                     dropped_ff, dropped_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]        rsp_key_code_ff, rsp_key_code_in;
   logic                     rsp_key_valid_ff, rsp_key_valid_in;
   logic                     rsp_level_ff, rsp_level_in;
   logic                     rsp_dropped_ff, rsp_dropped_in;

   logic                     req_accept;
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic [CODE_W-1:0]        ram_rd_data;
   logic [NUM_BUTTONS-1:0]   old_shift;
   logic [NUM_BUTTONS-1:0]   new_shift;
   logic [NUM_BUTTONS-1:0]   query_shift;
   logic                     press_seen;

   assign req_accept  = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign old_shift   = current_levels_ff >> idx_ff;
   assign new_shift   = levels_ff >> idx_ff;
   assign query_shift = current_levels_ff >> query_ff;
   assign press_seen  = (new_shift[0] != old_shift[0]) && (new_shift[0] == pressed_level_ff);

   bpeq_ram #(
      .WIDTH (CODE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (CODE_W'(idx_ff)),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in          = state_ff;
      pressed_level_in  = pressed_level_ff;
      current_levels_in = current_levels_ff;
      levels_in         = levels_ff;
      idx_in            = idx_ff;
      query_in          = query_ff;
      rd_ptr_in         = rd_ptr_ff;
      wr_ptr_in         = wr_ptr_ff;
      count_in          = count_ff;
      code_in           = code_ff;
      key_valid_in      = key_valid_ff;
      dropped_in        = dropped_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_key_code_in   = rsp_key_code_ff;
      rsp_key_valid_in  = rsp_key_valid_ff;
      rsp_level_in      = rsp_level_ff;
      rsp_dropped_in    = rsp_dropped_ff;
      ram_wr_en         = 1'b0;
      ram_rd_en         = 1'b0;

      if (csr_wr_en) begin
         pressed_level_in = csr_wr_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               query_in     = req_query_button;
               code_in      = KEY_NONE;
               key_valid_in = 1'b0;
               dropped_in   = 1'b0;
               unique case (req_operation)
                  bpeq_pkg::OP_SCAN: begin
                     levels_in = req_button_levels;
                     idx_in    = '0;
                     state_in  = ST_SCAN;
                  end
                  bpeq_pkg::OP_POP: begin
                     if (count_ff != '0) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_POP_WAIT;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  bpeq_pkg::OP_FLUSH: begin
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                     count_in  = '0;
                     state_in  = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (press_seen) begin
               if (count_ff != FULL_CNT) begin
                  ram_wr_en = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            if (idx_ff == LAST_IDX) begin
               current_levels_in = levels_ff;
               state_in          = ST_FINISH;
            end else begin
               idx_in = idx_ff + QUERY_W'(1);
            end
         end
         ST_POP_WAIT: begin
            code_in      = ram_rd_data;
            key_valid_in = 1'b1;
            rd_ptr_in    = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
            count_in     = count_ff - CNT_W'(1);
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_key_code_in  = code_ff;
               rsp_key_valid_in = key_valid_ff;
               rsp_dropped_in   = dropped_ff;
               rsp_level_in     = (32'(query_ff) < NUM_BUTTONS) ? query_shift[0] : 1'b0;
               state_in         = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         pressed_level_ff  <= 1'b1;
         current_levels_ff <= '0;
         rd_ptr_ff         <= '0;
         wr_ptr_ff         <= '0;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         pressed_level_ff  <= pressed_level_in;
         current_levels_ff <= current_levels_in;
         rd_ptr_ff         <= rd_ptr_in;
         wr_ptr_ff         <= wr_ptr_in;
         count_ff          <= count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      levels_ff        <= levels_in;
      idx_ff           <= idx_in;
      query_ff         <= query_in;
      code_ff          <= code_in;
      key_valid_ff     <= key_valid_in;
      dropped_ff       <= dropped_in;
      rsp_key_code_ff  <= rsp_key_code_in;
      rsp_key_valid_ff <= rsp_key_valid_in;
      rsp_level_ff     <= rsp_level_in;
      rsp_dropped_ff   <= rsp_dropped_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_key_code         = rsp_key_code_ff;
   assign rsp_key_valid        = rsp_key_valid_ff;
   assign rsp_queried_level    = rsp_level_ff;
   assign rsp_overflow_dropped = rsp_dropped_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("key count above FIFO depth");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (count_ff != FULL_CNT))
      else $error("key written into full FIFO");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_WAIT) |-> (count_ff != '0))
      else $error("pop read issued on empty FIFO");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_operation == bpeq_pkg::OP_SCAN)
      |=> (state_ff == ST_SCAN && idx_ff == '0))
      else $error("scan did not start at first button");

endmodule

`default_nettype wire

// ===== test/bpeq_key_checker.sv =====
// Checker for the button press event queue: predicts each result and compares it.
`timescale 1ns / 100ps

module bpeq_key_checker #(
   parameter int NUM_BUTTONS = 6,
   parameter int FIFO_DEPTH  = 32
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          csr_wr_en,
   input  wire logic                                          csr_wr_data,
   input  wire logic                                          req_valid,
   input  wire logic                                          req_stall,
   input  wire logic [bpeq_pkg::OP_W-1:0]                     req_operation,
   input  wire logic [NUM_BUTTONS-1:0]                        req_button_levels,
   input  wire logic [bpeq_pkg::addr_bits(NUM_BUTTONS)-1:0]   req_query_button,
   input  wire logic                                          rsp_valid,
   input  wire logic                                          rsp_stall,
   input  wire logic [$clog2(NUM_BUTTONS+1)-1:0]              rsp_key_code,
   input  wire logic                                          rsp_key_valid,
   input  wire logic                                          rsp_queried_level,
   input  wire logic                                          rsp_overflow_dropped,
   output int                                                 mismatches,
   output int                                                 outstanding
);

   localparam int KW = $clog2(NUM_BUTTONS + 1);
   localparam int QW = bpeq_pkg::addr_bits(NUM_BUTTONS);
   localparam logic [KW-1:0] KEY_NONE = KW'(NUM_BUTTONS);

   typedef struct packed {
      logic [KW-1:0] key_code;
      logic          key_valid;
      logic          queried_level;
      logic          overflow_dropped;
   } key_result_type;

   logic                   pressed_lvl;
   logic [NUM_BUTTONS-1:0] stored_levels;
   logic [KW-1:0]          key_mem [FIFO_DEPTH];
   int                     rd_ptr;
   int                     wr_ptr;
   int                     key_cnt;
   int                     err_cnt;
   key_result_type         key_results_due [$];
   key_result_type         seen;
   key_result_type         want;

   function automatic key_result_type apply_key_op(
      input logic [bpeq_pkg::OP_W-1:0] op,
      input logic [NUM_BUTTONS-1:0]    levels,
      input logic [QW-1:0]             query);
      key_result_type r;
      int             i;
      r = '{key_code: KEY_NONE, key_valid: 1'b0, queried_level: 1'b0,
            overflow_dropped: 1'b0};
      case (op)
         bpeq_pkg::OP_SCAN: begin
            for (i = 0; i < NUM_BUTTONS; i++) begin
               if (levels[i] != stored_levels[i] && levels[i] == pressed_lvl) begin
                  if (key_cnt >= FIFO_DEPTH) begin
                     r.overflow_dropped = 1'b1;
                  end else begin
                     key_mem[wr_ptr] = KW'(i);
                     wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                     key_cnt++;
                  end
               end
            end
            stored_levels = levels;
         end
         bpeq_pkg::OP_POP: begin
            if (key_cnt != 0) begin
               r.key_code  = key_mem[rd_ptr];
               r.key_valid = 1'b1;
               rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
               key_cnt--;
            end
         end
         bpeq_pkg::OP_FLUSH: begin
            rd_ptr  = 0;
            wr_ptr  = 0;
            key_cnt = 0;
         end
         default: ;
      endcase
      if (query < NUM_BUTTONS) r.queried_level = stored_levels[query];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pressed_lvl   = 1'b1;
         stored_levels = '0;
         rd_ptr        = 0;
         wr_ptr        = 0;
         key_cnt       = 0;
         key_results_due.delete();
      end else begin
         if (csr_wr_en) pressed_lvl = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            seen = '{key_code: rsp_key_code, key_valid: rsp_key_valid,
                     queried_level: rsp_queried_level,
                     overflow_dropped: rsp_overflow_dropped};
            if (key_results_due.size() == 0) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("%0t: result with none due: code=%0d valid=%0b %s",
                           $realtime, seen.key_code, seen.key_valid,
                           $sformatf("level=%0b drop=%0b", seen.queried_level,
                                     seen.overflow_dropped));
            end else begin
               want = key_results_due.pop_front();
               if (seen != want) begin
                  err_cnt++;
                  if (err_cnt <= 10)
                     $display("%0t: mismatch exp %s, got %s", $realtime,
                              $sformatf("code=%0d valid=%0b level=%0b drop=%0b",
                                        want.key_code, want.key_valid,
                                        want.queried_level, want.overflow_dropped),
                              $sformatf("code=%0d valid=%0b level=%0b drop=%0b",
                                        seen.key_code, seen.key_valid,
                                        seen.queried_level, seen.overflow_dropped));
               end
            end
         end
         if (req_valid && !req_stall)
            key_results_due.push_back(apply_key_op(req_operation, req_button_levels,
                                                   req_query_button));
      end
      mismatches  <= err_cnt;
      outstanding <= key_results_due.size();
   end

endmodule

// ===== test/tb_button_press_event_queue_core.sv =====
// Testbench top for the button press event queue: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module tb_button_press_event_queue_core;

   localparam int NB = 6;
   localparam int DEPTH = 32;
   localparam logic [bpeq_pkg::OP_W-1:0] OP_NONE = 2'd3;
   localparam int IDLE_LIMIT = 5000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = '0;
   logic [5:0] req_button_levels = '0;
   logic [2:0] req_query_button = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_key_code;
   logic       rsp_key_valid;
   logic       rsp_queried_level;
   logic       rsp_overflow_dropped;
   int         mismatches;
   int         outstanding;
   int         items_sent = 0;
   int         idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   button_press_event_queue_core #(.NUM_BUTTONS(NB), .FIFO_DEPTH(DEPTH)) u_top (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_valid, .req_stall, .req_operation, .req_button_levels, .req_query_button,
      .rsp_valid, .rsp_stall, .rsp_key_code, .rsp_key_valid, .rsp_queried_level,
      .rsp_overflow_dropped
   );

   bpeq_key_checker #(.NUM_BUTTONS(NB), .FIFO_DEPTH(DEPTH)) u_checker (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_valid, .req_stall, .req_operation, .req_button_levels, .req_query_button,
      .rsp_valid, .rsp_stall, .rsp_key_code, .rsp_key_valid, .rsp_queried_level,
      .rsp_overflow_dropped, .mismatches, .outstanding
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [5:0] levels,
                            input logic [2:0] query);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_button_levels <= levels;
      req_query_button  <= query;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_pressed_level(input logic value);
      drain();
      repeat (12) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // receiver pacing, with one long hold-off while the sender keeps offering
   initial begin : rsp_pacing
      int  stall_left;
      int  open_left;
      bit  long_done;
      stall_left = 0;
      open_left  = 0;
      long_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (!long_done && items_sent >= 60) begin
            long_done  = 1'b1;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (open_left > 0) begin
               open_left--;
            end else begin
               stall_left = pick_gap();
               open_left  = $urandom_range(0, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int         k;
      int         p;
      int         n;
      int         pick;
      int         pop_pct [4];
      logic [1:0] op;
      logic [5:0] levels;
      pop_pct = '{35, 40, 12, 30};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(bpeq_pkg::OP_POP, 6'h2A, 3'd0);
      send_item(OP_NONE, 6'h15, 3'd7);
      send_item(bpeq_pkg::OP_SCAN, 6'h3F, 3'd5);
      send_item(bpeq_pkg::OP_POP, 6'h00, 3'd6);
      send_item(bpeq_pkg::OP_FLUSH, 6'h3F, 3'd1);
      send_item(bpeq_pkg::OP_POP, 6'h00, 3'd2);
      // fill past full: six presses per pass of all buttons
      for (k = 0; k < 6; k++) begin
         send_item(bpeq_pkg::OP_SCAN, 6'h00, 3'(k));
         send_item(bpeq_pkg::OP_SCAN, 6'h3F, 3'(k + 1));
      end
      send_item(bpeq_pkg::OP_POP, 6'h00, 3'd3);
      send_item(bpeq_pkg::OP_POP, 6'h00, 3'd4);
      send_item(bpeq_pkg::OP_SCAN, 6'h15, 3'd1);
      write_pressed_level(1'b0);
      send_item(bpeq_pkg::OP_SCAN, 6'h00, 3'd0);
      send_item(bpeq_pkg::OP_FLUSH, 6'h00, 3'd2);

      for (p = 0; p < 4; p++) begin
         write_pressed_level(p[0] ? 1'b0 : 1'b1);
         for (n = 0; n < 100; n++) begin
            if (p == 1 && n == 50) drain();
            pick = $urandom_range(0, 99);
            if (pick < pop_pct[p]) op = bpeq_pkg::OP_POP;
            else if (pick < pop_pct[p] + 5) op = bpeq_pkg::OP_FLUSH;
            else if (pick < pop_pct[p] + 8) op = OP_NONE;
            else op = bpeq_pkg::OP_SCAN;
            pick = $urandom_range(0, 19);
            if (pick == 0) levels = 6'h00;
            else if (pick == 1) levels = 6'h3F;
            else levels = 6'($urandom_range(0, 63));
            send_item(op, levels, 3'($urandom_range(0, 7)));
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
